// File: rtl/core/spe_pkg.sv
`timescale 1ns / 1ps

package spe_pkg;

    // Field widths
    localparam int POS_W    = 10;
    localparam int CHAN_W   = 2;
    localparam int PULSE_W  = 12;
    localparam int STEP_W   = 6;
    localparam int OFFSET_W = 11;
    localparam int APB_DW   = 32;
    localparam int APB_AW   = 4;

    typedef logic [POS_W-1:0]    t_pos;
    typedef logic [CHAN_W-1:0]   t_chan;
    typedef logic [PULSE_W-1:0]  t_pulse;
    typedef logic [STEP_W-1:0]   t_step;
    typedef logic [OFFSET_W-1:0] t_offset;

    // Item kinds
    typedef enum logic {
        KIND_TICK = 1'b0,
        KIND_SET  = 1'b1
    } t_kind;

    // Register map, word index (byte address / 4)
    typedef enum logic [1:0] {
        REG_DEAD_LOW     = 2'd0,
        REG_DEAD_HIGH    = 2'd1,
        REG_MAX_STEP     = 2'd2,
        REG_PULSE_OFFSET = 2'd3
    } t_reg_idx;

    // Reset values
    localparam t_pos    DEAD_LOW_RST  = 10'd500;
    localparam t_pos    DEAD_HIGH_RST = 10'd524;
    localparam t_step   MAX_STEP_RST  = 6'd13;
    localparam t_offset OFFSET_RST    = 11'd500;
    localparam t_pos    POS_MID       = 10'd512;

    // Per-channel state word: {armed, target, position}
    typedef struct packed {
        logic armed;
        t_pos target;
        t_pos position;
    } t_chan_state;

    localparam t_chan_state STATE_RST = '{armed: 1'b1, target: POS_MID, position: POS_MID};

endpackage

// File: rtl/core/spe_in_if.sv
`timescale 1ns / 1ps

interface spe_in_if;
    import spe_pkg::*;

    logic  valid;
    logic  ready;
    t_kind kind;
    t_chan channel;
    t_pos  joystick_sample;
    t_pos  target_value;

    modport source (
        output valid, kind, channel, joystick_sample, target_value,
        input  ready
    );

    modport sink (
        input  valid, kind, channel, joystick_sample, target_value,
        output ready
    );

endinterface

// File: rtl/core/spe_out_if.sv
`timescale 1ns / 1ps

interface spe_out_if;
    import spe_pkg::*;

    logic   valid;
    logic   ready;
    t_chan  out_channel;
    t_pos   position;
    t_pulse pulse_width;
    logic   easing;

    modport source (
        output valid, out_channel, position, pulse_width, easing,
        input  ready
    );

    modport sink (
        input  valid, out_channel, position, pulse_width, easing,
        output ready
    );

endinterface

// File: rtl/core/spe_ram.sv
`timescale 1ns / 1ps

// Simple dual-port RAM, one write and one registered read port
module spe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/servo_position_easer_top.sv
`timescale 1ns / 1ps

// Servo position easer. Each transfer on i_in is either a set-target item, which stores a
// target for one channel and arms easing, or a tick, which advances that channel and returns
// one transfer on o_out with the new position, its pulse width and the easing flag. Items
// whose channel is not below CHANNELS are taken and dropped. The block takes one item per
// cycle sustained, with stalls only when o_out back-pressures; a tick's result reaches o_out
// through RAM read with input capture, then update and write-back, then pulse scaling into
// the output register.
// Per-channel state sits in a small RAM read on input capture; the update stage writes it back
// and forwards its own write to the next item when both hit the same channel. Reset takes
// effect at once through per-channel valid bits, so there is no clearing pass. Registers on
// the APB port should be written only while no item is in flight.
module servo_position_easer_top #(
    parameter int CHANNELS = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    spe_in_if.sink                        i_in,
    spe_out_if.source                     o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [spe_pkg::APB_AW-1:0]    paddr,
    input  logic [spe_pkg::APB_DW-1:0]    pwdata,
    output logic [spe_pkg::APB_DW-1:0]    prdata,
    output logic                          pready
);
    import spe_pkg::*;

    localparam int AW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int WORD_W = $bits(t_chan_state);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    t_pos    r_dead_low;
    t_pos    r_dead_high;
    t_step   r_max_step;
    t_offset r_pulse_offset;
    logic    cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dead_low     <= DEAD_LOW_RST;
            r_dead_high    <= DEAD_HIGH_RST;
            r_max_step     <= MAX_STEP_RST;
            r_pulse_offset <= OFFSET_RST;
        end else if (cfg_wr) begin
            case (t_reg_idx'(paddr[3:2]))
                REG_DEAD_LOW:     r_dead_low     <= pwdata[POS_W-1:0];
                REG_DEAD_HIGH:    r_dead_high    <= pwdata[POS_W-1:0];
                REG_MAX_STEP:     r_max_step     <= pwdata[STEP_W-1:0];
                REG_PULSE_OFFSET: r_pulse_offset <= pwdata[OFFSET_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        case (t_reg_idx'(paddr[3:2]))
            REG_DEAD_LOW:     prdata = APB_DW'(r_dead_low);
            REG_DEAD_HIGH:    prdata = APB_DW'(r_dead_high);
            REG_MAX_STEP:     prdata = APB_DW'(r_max_step);
            REG_PULSE_OFFSET: prdata = APB_DW'(r_pulse_offset);
            default:          prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Pipeline control
    // ------------------------------------------------------------------
    logic          r_s1_v;
    logic          r_s2_v;
    logic          r_out_v;
    logic          out_free;
    logic          s2_go;
    logic          s2_free;
    logic          s1_go;
    logic          in_acc;
    logic          in_range;
    logic [AW-1:0] in_addr;

    t_kind         r_s1_kind;
    logic [AW-1:0] r_s1_addr;
    t_chan         r_s1_ch;
    t_pos          r_s1_sample;
    t_pos          r_s1_target;
    logic          r_s1_ent_vld;
    logic          r_s1_fwd;

    assign out_free = !r_out_v || o_out.ready;
    assign s2_go    = r_s2_v && out_free;
    assign s2_free  = !r_s2_v || s2_go;
    // set-target items leave no result, so they never wait on stage 2
    assign s1_go    = r_s1_v && ((r_s1_kind == KIND_SET) || s2_free);
    assign i_in.ready = !r_s1_v || s1_go;
    assign in_acc   = i_in.valid && i_in.ready;
    assign in_range = (32'(i_in.channel) < CHANNELS);
    assign in_addr  = AW'(i_in.channel);

    // ------------------------------------------------------------------
    // State RAM with per-channel valid bits standing in for the reset value
    // ------------------------------------------------------------------
    logic [CHANNELS-1:0] r_ent_vld;
    logic [WORD_W-1:0]   ram_rdata;
    t_chan_state         wr_state;
    t_chan_state         r_fw_state;
    t_chan_state         cur;

    spe_ram #(
        .WIDTH (WORD_W),
        .DEPTH (CHANNELS)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (s1_go),
        .i_waddr (r_s1_addr),
        .i_wdata (wr_state),
        .i_re    (in_acc && in_range),
        .i_raddr (in_addr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent_vld <= '0;
        end else if (s1_go) begin
            r_ent_vld[r_s1_addr] <= 1'b1;
        end
    end

    // Stage 1 capture; forward flag set when the write in flight hits the same channel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_v <= in_acc && in_range;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_kind    <= i_in.kind;
            r_s1_addr    <= in_addr;
            r_s1_ch      <= i_in.channel;
            r_s1_sample  <= i_in.joystick_sample;
            r_s1_target  <= i_in.target_value;
            r_s1_ent_vld <= in_range && r_ent_vld[in_addr];
            r_s1_fwd     <= s1_go && (r_s1_addr == in_addr);
        end
        if (s1_go) begin
            r_fw_state <= wr_state;
        end
    end

    // Current channel state: forwarded write, RAM word or reset value
    always_comb begin
        if (r_s1_fwd) begin
            cur = r_fw_state;
        end else if (r_s1_ent_vld) begin
            cur = t_chan_state'(ram_rdata);
        end else begin
            cur = STATE_RST;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: easing toward the target
    // ------------------------------------------------------------------
    logic                  ez_up;
    t_pos                  ez_mag;
    logic [STEP_W:0]       ez_raw;
    logic [STEP_W:0]       ez_cap;
    logic [STEP_W:0]       ez_step;
    logic                  ez_done;
    t_pos                  ez_pos;

    always_comb begin
        ez_up   = cur.target > cur.position;
        ez_mag  = ez_up ? (cur.target - cur.position) : (cur.position - cur.target);
        ez_raw  = (STEP_W+1)'(ez_mag[POS_W-1:4]) + (STEP_W+1)'(1);
        // zero max_step behaves as one
        ez_cap  = (r_max_step == '0) ? (STEP_W+1)'(1) : (STEP_W+1)'(r_max_step);
        ez_step = (ez_raw > ez_cap) ? ez_cap : ez_raw;
        // reaching or passing the target snaps to it (also covers zero distance)
        ez_done = POS_W'(ez_step) >= ez_mag;
        if (ez_done) begin
            ez_pos = cur.target;
        end else if (ez_up) begin
            ez_pos = cur.position + POS_W'(ez_step);
        end else begin
            ez_pos = cur.position - POS_W'(ez_step);
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: joystick nudge outside the deadzone, saturating
    // ------------------------------------------------------------------
    logic          nu_move;
    logic          nu_up;
    t_pos          nu_below;
    logic [2:0]    nu_mag;
    logic [POS_W:0] nu_sum;
    t_pos          nu_pos;

    always_comb begin
        nu_move  = (r_s1_sample < r_dead_low) || (r_s1_sample > r_dead_high);
        nu_up    = r_s1_sample[POS_W-1];
        nu_below = POS_MID - r_s1_sample;
        // truncated toward zero: magnitude is the distance from mid-scale over 128
        nu_mag   = nu_up ? {1'b0, r_s1_sample[8:7]} : nu_below[9:7];
        nu_sum   = (POS_W+1)'(cur.position) + (POS_W+1)'(nu_mag);
        if (!nu_move) begin
            nu_pos = cur.position;
        end else if (nu_up) begin
            nu_pos = nu_sum[POS_W] ? '1 : nu_sum[POS_W-1:0];
        end else begin
            nu_pos = (cur.position < POS_W'(nu_mag)) ? '0 : cur.position - POS_W'(nu_mag);
        end
    end

    // New state word for write-back
    always_comb begin
        wr_state = cur;
        if (r_s1_kind == KIND_SET) begin
            wr_state.target = r_s1_target;
            wr_state.armed  = 1'b1;
        end else if (cur.armed) begin
            wr_state.position = ez_pos;
            wr_state.armed    = !ez_done;
        end else begin
            wr_state.position = nu_pos;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: tick results waiting for pulse scaling
    // ------------------------------------------------------------------
    t_chan r_s2_ch;
    t_pos  r_s2_pos;
    logic  r_s2_easing;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (s2_free) begin
            r_s2_v <= s1_go && (r_s1_kind == KIND_TICK);
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_free) begin
            r_s2_ch     <= r_s1_ch;
            r_s2_pos    <= wr_state.position;
            r_s2_easing <= wr_state.armed;
        end
    end

    // Pulse width: floor(pos*2000/1023) + offset, with x = 1024a + b so
    // x/1023 = a + (a+b)/1023 and a+b stays below 3*1023
    logic [20:0]     pw_x;
    logic [10:0]     pw_a;
    logic [POS_W-1:0] pw_b;
    logic [11:0]     pw_sum;
    logic [10:0]     pw_q;
    t_pulse          pw_pulse;

    always_comb begin
        pw_x   = 21'(r_s2_pos) * 21'd2000;
        pw_a   = pw_x[20:10];
        pw_b   = pw_x[9:0];
        pw_sum = 12'(pw_a) + 12'(pw_b);
        if (pw_sum >= 12'd2046) begin
            pw_q = pw_a + 11'd2;
        end else if (pw_sum >= 12'd1023) begin
            pw_q = pw_a + 11'd1;
        end else begin
            pw_q = pw_a;
        end
        pw_pulse = PULSE_W'(pw_q) + PULSE_W'(r_pulse_offset);
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    t_chan  r_out_ch;
    t_pos   r_out_pos;
    t_pulse r_out_pulse;
    logic   r_out_easing;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (out_free) begin
            r_out_v <= s2_go;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_go) begin
            r_out_ch     <= r_s2_ch;
            r_out_pos    <= r_s2_pos;
            r_out_pulse  <= pw_pulse;
            r_out_easing <= r_s2_easing;
        end
    end

    assign o_out.valid       = r_out_v;
    assign o_out.out_channel = r_out_ch;
    assign o_out.position    = r_out_pos;
    assign o_out.pulse_width = r_out_pulse;
    assign o_out.easing      = r_out_easing;

endmodule
